// ===== rtl/bdai_pkg.sv =====
// Shared types, constants, curve table and microprogram of the backlight to dim-alpha block.
package bdai_pkg;

    // Field widths.
    localparam int LEVEL_W      = 12;
    localparam int ALPHA_W      = 8;
    localparam int LEVEL_DATA_W = 16;   // level field padded to whole bytes

    // Curve table.
    localparam int TABLE_POINTS_DEF = 20;
    localparam int TABLE_SLOTS      = 32;
    localparam int IDX_W            = $clog2(TABLE_SLOTS);
    localparam int CURVE_LVL_W      = 10;
    localparam int LOW_LEVEL_LIMIT  = 3;

    localparam logic [CURVE_LVL_W-1:0] CURVE_LEVEL [TABLE_SLOTS] = '{
        10'd0,   10'd1,   10'd2,   10'd3,   10'd4,
        10'd6,   10'd10,  10'd20,  10'd30,  10'd45,
        10'd70,  10'd100, 10'd150, 10'd227, 10'd300,
        10'd400, 10'd500, 10'd600, 10'd800, 10'd1023,
        10'd1023, 10'd1023, 10'd1023, 10'd1023,
        10'd1023, 10'd1023, 10'd1023, 10'd1023,
        10'd1023, 10'd1023, 10'd1023, 10'd1023
    };

    localparam logic [ALPHA_W-1:0] CURVE_ALPHA [TABLE_SLOTS] = '{
        8'hff, 8'hee, 8'he8, 8'he6, 8'he5,
        8'he4, 8'he0, 8'hd5, 8'hce, 8'hc6,
        8'hb7, 8'had, 8'ha0, 8'h8a, 8'h80,
        8'h6e, 8'h5b, 8'h50, 8'h38, 8'h18,
        8'h18, 8'h18, 8'h18, 8'h18,
        8'h18, 8'h18, 8'h18, 8'h18,
        8'h18, 8'h18, 8'h18, 8'h18
    };

    // Datapath widths: numerators stay below 2^22, divisors below 2^10.
    localparam int DY_W          = ALPHA_W + 1;
    localparam int DIV_NW        = 23;
    localparam int DIV_MAG_W     = DIV_NW - 1;
    localparam int DIV_DW        = CURVE_LVL_W + 1;
    localparam int DIV_DMAG_W    = CURVE_LVL_W;
    localparam int DIV_BITS      = 2;
    localparam int SUM_W         = DIV_NW + 1;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDX_INC,
        OP_LOAD_SEG,
        OP_DIV_A,
        OP_SAVE_T,
        OP_DIV_B,
        OP_DIV_C,
        OP_SAVE_BEND,
        OP_OUT_CALC,
        OP_OUT_TAIL,
        OP_OUT_ZERO,
        OP_OUT_OVR,
        OP_OUT_LAST
    } t_op;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_HBM_OFF,
        C_OVR,
        C_LOW,
        C_HIT,
        C_NOT_END,
        C_DIV_BUSY,
        C_DY_ZERO
    } t_cond;

    localparam int PC_W = 5;

    localparam logic [PC_W-1:0] S_CHK_HBM  = 5'd0;
    localparam logic [PC_W-1:0] S_CHK_OVR  = 5'd1;
    localparam logic [PC_W-1:0] S_CHK_LOW  = 5'd2;
    localparam logic [PC_W-1:0] S_SCAN     = 5'd3;
    localparam logic [PC_W-1:0] S_NEXT     = 5'd4;
    localparam logic [PC_W-1:0] S_OUT_TAIL = 5'd5;
    localparam logic [PC_W-1:0] S_SEG      = 5'd6;
    localparam logic [PC_W-1:0] S_DIV_A    = 5'd7;
    localparam logic [PC_W-1:0] S_WAIT_A   = 5'd8;
    localparam logic [PC_W-1:0] S_SAVE_T   = 5'd9;
    localparam logic [PC_W-1:0] S_DIV_B    = 5'd10;
    localparam logic [PC_W-1:0] S_WAIT_B   = 5'd11;
    localparam logic [PC_W-1:0] S_DIV_C    = 5'd12;
    localparam logic [PC_W-1:0] S_WAIT_C   = 5'd13;
    localparam logic [PC_W-1:0] S_SAVE_B   = 5'd14;
    localparam logic [PC_W-1:0] S_FIN      = 5'd15;
    localparam logic [PC_W-1:0] S_OUT_ZERO = 5'd16;
    localparam logic [PC_W-1:0] S_OUT_OVR  = 5'd17;
    localparam logic [PC_W-1:0] S_OUT_LAST = 5'd18;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
        logic             last;
    } t_uword;

    typedef struct packed {
        logic hbm_off;
        logic ovr;
        logic low;
        logic hit;
        logic not_end;
        logic div_busy;
        logic dy_zero;
        logic out_blocked;
    } t_status;

    function automatic t_uword uw(input t_op op, input t_cond cond,
                                  input logic [PC_W-1:0] target, input logic last);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    // Microprogram. A step jumps to its target when its condition holds,
    // otherwise it falls through; a step marked last ends the transaction.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            S_CHK_HBM:  w = uw(OP_NOP,       C_HBM_OFF,  S_OUT_ZERO, 1'b0);
            S_CHK_OVR:  w = uw(OP_NOP,       C_OVR,      S_OUT_OVR,  1'b0);
            S_CHK_LOW:  w = uw(OP_NOP,       C_LOW,      S_OUT_LAST, 1'b0);
            S_SCAN:     w = uw(OP_NOP,       C_HIT,      S_SEG,      1'b0);
            S_NEXT:     w = uw(OP_IDX_INC,   C_NOT_END,  S_SCAN,     1'b0);
            S_OUT_TAIL: w = uw(OP_OUT_TAIL,  C_NEVER,    S_CHK_HBM,  1'b1);
            S_SEG:      w = uw(OP_LOAD_SEG,  C_NEVER,    S_CHK_HBM,  1'b0);
            S_DIV_A:    w = uw(OP_DIV_A,     C_NEVER,    S_CHK_HBM,  1'b0);
            S_WAIT_A:   w = uw(OP_NOP,       C_DIV_BUSY, S_WAIT_A,   1'b0);
            S_SAVE_T:   w = uw(OP_SAVE_T,    C_DY_ZERO,  S_FIN,      1'b0);
            S_DIV_B:    w = uw(OP_DIV_B,     C_NEVER,    S_CHK_HBM,  1'b0);
            S_WAIT_B:   w = uw(OP_NOP,       C_DIV_BUSY, S_WAIT_B,   1'b0);
            S_DIV_C:    w = uw(OP_DIV_C,     C_NEVER,    S_CHK_HBM,  1'b0);
            S_WAIT_C:   w = uw(OP_NOP,       C_DIV_BUSY, S_WAIT_C,   1'b0);
            S_SAVE_B:   w = uw(OP_SAVE_BEND, C_NEVER,    S_CHK_HBM,  1'b0);
            S_FIN:      w = uw(OP_OUT_CALC,  C_NEVER,    S_CHK_HBM,  1'b1);
            S_OUT_ZERO: w = uw(OP_OUT_ZERO,  C_NEVER,    S_CHK_HBM,  1'b1);
            S_OUT_OVR:  w = uw(OP_OUT_OVR,   C_NEVER,    S_CHK_HBM,  1'b1);
            S_OUT_LAST: w = uw(OP_OUT_LAST,  C_NEVER,    S_CHK_HBM,  1'b1);
            default:    w = uw(OP_NOP,       C_NEVER,    S_CHK_HBM,  1'b1);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/bdai_div.sv =====
// Iterative signed divider, two quotient bits per cycle, truncating towards zero.
module bdai_div import bdai_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIV_NW-1:0] i_num,
    input  logic signed [DIV_DW-1:0] i_den,
    output logic                     o_busy,
    output logic signed [DIV_NW-1:0] o_quot
);

    localparam int STEPS = (DIV_MAG_W + DIV_BITS - 1) / DIV_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic                  r_neg;
    logic [DIV_MAG_W-1:0]  r_q;
    logic [DIV_DMAG_W:0]   r_rem;
    logic [DIV_DMAG_W-1:0] r_d;

    logic [DIV_MAG_W-1:0]  num_mag;
    logic [DIV_DMAG_W-1:0] den_mag;
    logic [DIV_MAG_W-1:0]  step_q;
    logic [DIV_DMAG_W:0]   step_rem;

    logic signed [DIV_NW-1:0] num_abs;
    logic signed [DIV_DW-1:0] den_abs;

    assign num_abs = i_num[DIV_NW-1] ? -i_num : i_num;
    assign den_abs = i_den[DIV_DW-1] ? -i_den : i_den;
    assign num_mag = num_abs[DIV_MAG_W-1:0];
    assign den_mag = den_abs[DIV_DMAG_W-1:0];

    // Restoring division, DIV_BITS bits per cycle.
    always_comb begin
        step_rem = r_rem;
        step_q   = r_q;
        for (int k = 0; k < DIV_BITS; k++) begin
            step_rem = {step_rem[DIV_DMAG_W-1:0], step_q[DIV_MAG_W-1]};
            step_q   = {step_q[DIV_MAG_W-2:0], 1'b0};
            if (step_rem >= {1'b0, r_d}) begin
                step_rem  = step_rem - {1'b0, r_d};
                step_q[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[DIV_NW-1] ^ i_den[DIV_DW-1];
            r_q   <= num_mag;
            r_rem <= '0;
            r_d   <= den_mag;
        end else if (r_cnt != '0) begin
            r_q   <= step_q;
            r_rem <= step_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

// ===== rtl/bdai_dp.sv =====
// Datapath: request registers, curve search index, interpolation terms and result register.
module bdai_dp import bdai_pkg::*; #(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic               i_hbm,
    input  logic               i_cfg_we,
    input  logic [ALPHA_W-1:0] i_cfg_data,
    input  t_op                i_op,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [ALPHA_W-1:0] o_out_data,
    output t_status            o_status
);

    localparam int COUNT = (TABLE_POINTS > TABLE_SLOTS) ? TABLE_SLOTS : TABLE_POINTS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COUNT - 1);

    logic [LEVEL_W-1:0]       r_x;
    logic                     r_hbm;
    logic [IDX_W-1:0]         r_idx;
    logic [CURVE_LVL_W-1:0]   r_u;
    logic [CURVE_LVL_W-1:0]   r_v;
    logic [CURVE_LVL_W-1:0]   r_dx;
    logic signed [DY_W-1:0]   r_dy;
    logic [ALPHA_W-1:0]       r_ya;
    logic signed [DIV_NW-1:0] r_twice;
    logic signed [DIV_NW-1:0] r_bend;
    logic [ALPHA_W-1:0]       r_last;
    logic [ALPHA_W-1:0]       r_override;
    logic                     r_out_valid;
    logic [ALPHA_W-1:0]       r_out_data;

    logic [IDX_W-1:0]         idx_lo;
    logic [CURVE_LVL_W-1:0]   lvl_hi;
    logic [CURVE_LVL_W-1:0]   lvl_lo;
    logic                     div_start;
    logic                     div_busy;
    logic signed [DIV_NW-1:0] div_num;
    logic signed [DIV_DW-1:0] div_den;
    logic signed [DIV_NW-1:0] div_quot;
    logic signed [DIV_NW-1:0] twice_half;
    logic signed [SUM_W-1:0]  sum;
    logic [ALPHA_W-1:0]       sat;
    logic                     out_load;
    logic [ALPHA_W-1:0]       out_value;

    // The search starts at point one; point zero sits at level zero and can
    // never be hit by a level above the low limit.
    assign idx_lo = IDX_W'(r_idx - 1'b1);
    assign lvl_hi = CURVE_LEVEL[r_idx];
    assign lvl_lo = CURVE_LEVEL[idx_lo];

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (i_op)
            OP_DIV_A: begin
                div_start = 1'b1;
                div_num   = (DIV_NW'(r_dy) * DIV_NW'($signed({1'b0, r_u}))) <<< 1;
                div_den   = DIV_DW'($signed({1'b0, r_dx}));
            end
            OP_DIV_B: begin
                div_start = 1'b1;
                div_num   = -((DIV_NW'($signed({1'b0, r_u}))
                              * DIV_NW'($signed({1'b0, r_v}))) <<< 1);
                div_den   = DIV_DW'(r_dy);
            end
            OP_DIV_C: begin
                div_start = 1'b1;
                div_num   = div_quot;
                div_den   = -DIV_DW'($signed({1'b0, r_dx}));
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    bdai_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // Halving with remainder rounding: odd positive values round up.
    assign twice_half = r_twice >>> 1;
    assign sum = SUM_W'($signed({1'b0, r_ya})) + SUM_W'(twice_half)
               + SUM_W'($signed({1'b0, r_twice[0] & ~r_twice[DIV_NW-1]}))
               + SUM_W'(r_bend);

    always_comb begin
        if (sum[SUM_W-1]) begin
            sat = '0;
        end else if (|sum[SUM_W-2:ALPHA_W]) begin
            sat = '1;
        end else begin
            sat = sum[ALPHA_W-1:0];
        end
    end

    always_comb begin
        out_load  = 1'b1;
        unique case (i_op)
            OP_OUT_CALC: out_value = sat;
            OP_OUT_TAIL: out_value = CURVE_ALPHA[LAST_IDX];
            OP_OUT_OVR:  out_value = r_override;
            OP_OUT_LAST: out_value = r_last;
            OP_OUT_ZERO: out_value = '0;
            default: begin
                out_load  = 1'b0;
                out_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_override  <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_op == OP_OUT_CALC || i_op == OP_OUT_TAIL) begin
                r_last <= out_value;
            end
            if (i_cfg_we) begin
                r_override <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_value;
        end
        if (i_accept) begin
            r_x   <= i_level;
            r_hbm <= i_hbm;
            r_idx <= IDX_W'(1);
        end else if (i_op == OP_IDX_INC) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_op == OP_LOAD_SEG) begin
            r_u    <= CURVE_LVL_W'(r_x) - lvl_lo;
            r_v    <= lvl_hi - CURVE_LVL_W'(r_x);
            r_dx   <= lvl_hi - lvl_lo;
            r_dy   <= $signed({1'b0, CURVE_ALPHA[r_idx]}) - $signed({1'b0, CURVE_ALPHA[idx_lo]});
            r_ya   <= CURVE_ALPHA[idx_lo];
            r_bend <= '0;
        end
        if (i_op == OP_SAVE_T) begin
            r_twice <= div_quot;
        end
        if (i_op == OP_SAVE_BEND) begin
            r_bend <= div_quot;
        end
    end

    assign o_status.hbm_off     = ~r_hbm;
    assign o_status.ovr         = (r_override != '0);
    assign o_status.low         = (r_x <= LEVEL_W'(LOW_LEVEL_LIMIT));
    assign o_status.hit         = ({{(LEVEL_W-CURVE_LVL_W){1'b0}}, lvl_hi} >= r_x);
    assign o_status.not_end     = (r_idx != LAST_IDX);
    assign o_status.div_busy    = div_busy;
    assign o_status.dy_zero     = (r_dy == '0);
    assign o_status.out_blocked = r_out_valid & ~i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/bdai_seq.sv =====
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
module bdai_seq import bdai_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output logic    o_busy,
    output t_op     o_op
);

    logic [PC_W-1:0] r_pc;
    logic            r_busy;
    logic [PC_W-1:0] n_pc;
    logic            n_busy;
    t_uword          word;
    logic            cond_true;
    logic            stall;

    assign word = ucode(r_pc);

    always_comb begin
        unique case (word.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_HBM_OFF:  cond_true = i_status.hbm_off;
            C_OVR:      cond_true = i_status.ovr;
            C_LOW:      cond_true = i_status.low;
            C_HIT:      cond_true = i_status.hit;
            C_NOT_END:  cond_true = i_status.not_end;
            C_DIV_BUSY: cond_true = i_status.div_busy;
            C_DY_ZERO:  cond_true = i_status.dy_zero;
            default:    cond_true = 1'b0;
        endcase
    end

    // A final step waits while the previous result is still held.
    assign stall = word.last & i_status.out_blocked;
    assign o_op  = (r_busy && !stall) ? word.op : OP_NOP;

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_start) begin
            n_pc   = S_CHK_HBM;
            n_busy = 1'b1;
        end else if (r_busy && !stall) begin
            if (word.last) begin
                n_busy = 1'b0;
            end else if (cond_true) begin
                n_pc = word.target;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= S_CHK_HBM;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== rtl/backlight_to_dim_alpha_interp.sv =====
// Top level of the backlight to dim-alpha interpolator.
//
// Each input transaction carries a backlight level and the high-brightness
// flag; one output transaction returns the dim-layer alpha. With the flag
// clear the alpha is zero, a nonzero override register is returned as it is,
// and levels of three or below return the alpha last derived from the curve.
// Otherwise the level is searched in a constant level/alpha curve and
// interpolated between its neighbouring points (a rounded linear term plus a
// quadratic correction), saturated to 0..255 and remembered. A short
// microprogram steps a small datapath; one request is in work at a time, and
// a new one is taken while the previous result still waits on the output.
// These cases are checked in that order; the curve path then steps through the
// curve points one by one in the search and runs up to three divisions in the
// shared two-bit-per-cycle divider, and a level beyond the curve returns the
// alpha of the last curve point. The next request can be taken once the result
// has been loaded, and the final step of a request waits for as long as the
// previous result is still held on the output. The override register may only
// be written while no request is in work.
module backlight_to_dim_alpha_interp import bdai_pkg::*; #(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [LEVEL_DATA_W-1:0] s_axis_tdata,   // [11:0] brightness_level
    input  logic [0:0]              s_axis_tuser,   // [0] hbm_active
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [ALPHA_W-1:0]      m_axis_tdata,   // [7:0] dim-layer alpha
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [ALPHA_W-1:0]      i_cfg_data
);

    logic    seq_busy;
    logic    in_accept;
    logic    cfg_we;
    t_op     op;
    t_status status;

    // A request is taken whenever the sequencer is free.
    assign s_axis_tready = ~seq_busy;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    // The override register accepts a write in every cycle.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    bdai_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_accept),
        .i_status (status),
        .o_busy   (seq_busy),
        .o_op     (op)
    );

    bdai_dp #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_level     (s_axis_tdata[LEVEL_W-1:0]),
        .i_hbm       (s_axis_tuser[0]),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_op        (op),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_status    (status)
    );

    // The divider is only started once the previous division has finished.
    a_div_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_DIV_A || op == OP_DIV_B || op == OP_DIV_C) |-> !status.div_busy)
        else $error("divider started while busy");

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_OUT_CALC || op == OP_OUT_TAIL || op == OP_OUT_ZERO
         || op == OP_OUT_OVR || op == OP_OUT_LAST) |-> !status.out_blocked)
        else $error("result register overwritten");

    // With the flag clear and the output empty, an accepted request returns a zero on the output.
    a_flag_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !s_axis_tuser[0] && !m_axis_tvalid)
        |-> ##3 (m_axis_tvalid && m_axis_tdata == '0))
        else $error("flag-off request did not return zero");

endmodule
